### design/fdraw_pkg.sv
package fdraw_pkg;

   localparam int MAX_WIDTH  = 64;
   localparam int MAX_HEIGHT = 64;
   localparam int MEM_DEPTH  = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_W     = $clog2(MEM_DEPTH);
   localparam int DIM_W      = $clog2(((MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT) + 1);
   localparam int SIZE_W     = 7;
   localparam int LEN_W      = 15;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   // command codes
   localparam logic [2:0] CMD_PIXEL = 3'd0;
   localparam logic [2:0] CMD_HLINE = 3'd1;
   localparam logic [2:0] CMD_VLINE = 3'd2;
   localparam logic [2:0] CMD_RECT  = 3'd3;
   localparam logic [2:0] CMD_FILL  = 3'd4;
   localparam logic [2:0] CMD_READ  = 3'd5;

   // register indexes
   localparam logic [1:0] REG_ENABLE = 2'd0;
   localparam logic [1:0] REG_WIDTH  = 2'd1;
   localparam logic [1:0] REG_HEIGHT = 2'd2;
   localparam logic [1:0] REG_MODE   = 2'd3;

   typedef struct packed {
      logic [2:0]         req_type;
      logic signed [15:0] pos_x;
      logic signed [15:0] pos_y;
      logic signed [15:0] extent_a;
      logic signed [15:0] extent_b;
      logic [31:0]        draw_color;
   } req_payload_type;

   typedef struct packed {
      logic [31:0] read_data;
      logic        rejected;
   } rsp_payload_type;

   typedef struct packed {
      logic             enabled;
      logic             color_mode;
      logic [DIM_W-1:0] eff_w;
      logic [DIM_W-1:0] eff_h;
   } cfg_type;

endpackage

### design/fdraw_csr.sv
module fdraw_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [fdraw_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [fdraw_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [fdraw_pkg::CSR_DATA_W-1:0]    prdata,
   output fdraw_pkg::cfg_type                  cfg
);

   logic                           enabled_ff, enabled_in;
   logic [fdraw_pkg::SIZE_W-1:0]   width_ff, width_in;
   logic [fdraw_pkg::SIZE_W-1:0]   height_ff, height_in;
   logic                           mode_ff, mode_in;
   logic                           wr_hit;
   logic [1:0]                     reg_idx;

   assign reg_idx = paddr[3:2];
   assign wr_hit  = psel & penable & pwrite;

   always_comb begin
      enabled_in = enabled_ff;
      width_in   = width_ff;
      height_in  = height_ff;
      mode_in    = mode_ff;
      if (wr_hit) begin
         case (reg_idx)
            fdraw_pkg::REG_ENABLE: enabled_in = pwdata[0];
            fdraw_pkg::REG_WIDTH:  width_in   = pwdata[fdraw_pkg::SIZE_W-1:0];
            fdraw_pkg::REG_HEIGHT: height_in  = pwdata[fdraw_pkg::SIZE_W-1:0];
            fdraw_pkg::REG_MODE:   mode_in    = pwdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff <= 1'b0;
         width_ff   <= fdraw_pkg::SIZE_W'(1);
         height_ff  <= fdraw_pkg::SIZE_W'(1);
         mode_ff    <= 1'b0;
      end else begin
         enabled_ff <= enabled_in;
         width_ff   <= width_in;
         height_ff  <= height_in;
         mode_ff    <= mode_in;
      end
   end

   always_comb begin
      case (reg_idx)
         fdraw_pkg::REG_ENABLE: prdata = fdraw_pkg::CSR_DATA_W'(enabled_ff);
         fdraw_pkg::REG_WIDTH:  prdata = fdraw_pkg::CSR_DATA_W'(width_ff);
         fdraw_pkg::REG_HEIGHT: prdata = fdraw_pkg::CSR_DATA_W'(height_ff);
         fdraw_pkg::REG_MODE:   prdata = fdraw_pkg::CSR_DATA_W'(mode_ff);
         default:               prdata = '0;
      endcase
   end

   // zero acts as one, oversize clamps to the maximum
   always_comb begin
      cfg.enabled    = enabled_ff;
      cfg.color_mode = mode_ff;
      if (width_ff == '0) begin
         cfg.eff_w = fdraw_pkg::DIM_W'(1);
      end else if (int'(width_ff) > fdraw_pkg::MAX_WIDTH) begin
         cfg.eff_w = fdraw_pkg::DIM_W'(fdraw_pkg::MAX_WIDTH);
      end else begin
         cfg.eff_w = fdraw_pkg::DIM_W'(width_ff);
      end
      if (height_ff == '0) begin
         cfg.eff_h = fdraw_pkg::DIM_W'(1);
      end else if (int'(height_ff) > fdraw_pkg::MAX_HEIGHT) begin
         cfg.eff_h = fdraw_pkg::DIM_W'(fdraw_pkg::MAX_HEIGHT);
      end else begin
         cfg.eff_h = fdraw_pkg::DIM_W'(height_ff);
      end
   end

endmodule

### design/framebuffer_draw_engine_core.sv
// Frame drawing engine with an on-chip frame memory of one word per pixel.
// Commands arrive on the req_ channel (valid/ready); each transaction yields
// exactly one rsp_ transaction carrying read_data and rejected, in order.
// The frame registers sit behind the APB-style port (psel..pready); they are
// to be written only while no command is in flight; the block does not check.
// One command at a time: a command is checked, then a pixel, line or rectangle
// outline is drawn edge by edge by the edge walker, a fill writes every pixel
// of the frame in address order, and a read fetches one word from the frame
// memory. The single memory write port takes one pixel per cycle from the
// edge walker or the fill.
// req_ready is high whenever the sequencer is idle. A finished response is
// held in an output register, so the next command may be taken while the
// receiver stalls; the sequencer only waits at its final step when that
// register is still full.
// Reset clears the sequencer, the response register and the frame registers
// (disabled, 1 x 1 frame, 32-bit colour). The frame memory is not cleared and
// holds undefined data until written.
module framebuffer_draw_engine_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  fdraw_pkg::req_payload_type        req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output fdraw_pkg::rsp_payload_type        rsp_data,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [fdraw_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [fdraw_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [fdraw_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                              pready
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_SETUP,
      ST_WALK,
      ST_FILL,
      ST_READ,
      ST_RDATA,
      ST_DONE
   } state_type;

   // edge order of an outline
   localparam logic [1:0] SEG_TOP    = 2'd0;
   localparam logic [1:0] SEG_LEFT   = 2'd1;
   localparam logic [1:0] SEG_BOTTOM = 2'd2;
   localparam logic [1:0] SEG_RIGHT  = 2'd3;

   localparam int AW = fdraw_pkg::ADDR_W;
   localparam int DW = fdraw_pkg::DIM_W;
   localparam int LW = fdraw_pkg::LEN_W;

   fdraw_pkg::cfg_type cfg;

   state_type                    state_ff, state_in;
   fdraw_pkg::req_payload_type   cmd_ff, cmd_in;
   fdraw_pkg::rsp_payload_type   rsp_ff, rsp_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [31:0]                  res_data_ff, res_data_in;
   logic                         res_rej_ff, res_rej_in;
   logic [1:0]                   seg_ff, seg_in;
   logic [DW-1:0]                cur_x_ff, cur_x_in;
   logic [DW-1:0]                cur_y_ff, cur_y_in;
   logic [LW-1:0]                left_ff, left_in;
   logic                         horiz_ff, horiz_in;
   logic [AW-1:0]                fill_addr_ff, fill_addr_in;
   logic [AW:0]                  fill_count_ff, fill_count_in;
   logic                         wr_en_ff, wr_en_in;
   logic [AW-1:0]                wr_addr_ff, wr_addr_in;
   logic [31:0]                  wr_data_ff, wr_data_in;
   logic                         rd_en;
   logic [31:0]                  rd_data_ff;

   logic [31:0]                  frame_mem [fdraw_pkg::MEM_DEPTH];

   logic [DW-1:0]                mul_a;
   logic [2*DW-1:0]              product;
   logic [AW-1:0]                pix_addr;
   logic [16:0]                  x_ext, y_ext;
   logic [16:0]                  seg_base, seg_ext, seg_sum;
   logic [16:0]                  seg_x, seg_y;
   logic [LW-1:0]                seg_len;
   logic                         seg_vis, seg_last;
   logic                         ea_pos, eb_pos;
   logic [DW-1:0]                next_coord;
   logic                         edge_hit;

   function automatic logic in_frame(input logic [16:0] px, input logic [16:0] py,
                                     input logic [DW-1:0] w, input logic [DW-1:0] h);
      return !px[16] && (px < 17'(w)) && !py[16] && (py < 17'(h));
   endfunction

   fdraw_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .cfg     (cfg)
   );

   assign pready    = 1'b1;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // shared multiplier: frame area at check time, row offset otherwise
   assign mul_a    = (state_ff == ST_CHECK) ? cfg.eff_h : cur_y_ff;
   assign product  = mul_a * cfg.eff_w;
   assign pix_addr = product[AW-1:0] + AW'(cur_x_ff);

   assign x_ext  = {cmd_ff.pos_x[15], cmd_ff.pos_x};
   assign y_ext  = {cmd_ff.pos_y[15], cmd_ff.pos_y};
   assign ea_pos = !cmd_ff.extent_a[15] && (cmd_ff.extent_a != '0);
   assign eb_pos = !cmd_ff.extent_b[15] && (cmd_ff.extent_b != '0);

   // far edge start: base + extent - 1
   assign seg_base = (seg_ff == SEG_RIGHT) ? x_ext : y_ext;
   assign seg_ext  = (seg_ff == SEG_RIGHT) ? {cmd_ff.extent_a[15], cmd_ff.extent_a}
                                           : {cmd_ff.extent_b[15], cmd_ff.extent_b};
   assign seg_sum  = seg_base + seg_ext - 17'd1;
   assign seg_x    = (seg_ff == SEG_RIGHT) ? seg_sum : x_ext;
   assign seg_y    = (seg_ff == SEG_BOTTOM) ? seg_sum : y_ext;
   assign seg_vis  = in_frame(seg_x, seg_y, cfg.eff_w, cfg.eff_h);
   assign seg_last = (cmd_ff.req_type != fdraw_pkg::CMD_RECT) || (seg_ff == SEG_RIGHT);

   always_comb begin
      case (seg_ff)
         SEG_TOP: begin
            if (cmd_ff.req_type == fdraw_pkg::CMD_PIXEL) begin
               seg_len = LW'(1);
            end else begin
               seg_len = cmd_ff.extent_a[LW-1:0];
            end
         end
         SEG_LEFT: begin
            if (cmd_ff.req_type == fdraw_pkg::CMD_VLINE) begin
               seg_len = cmd_ff.extent_a[LW-1:0];
            end else begin
               seg_len = cmd_ff.extent_b[LW-1:0];
            end
         end
         SEG_BOTTOM: seg_len = cmd_ff.extent_a[LW-1:0];
         SEG_RIGHT:  seg_len = cmd_ff.extent_b[LW-1:0];
         default:    seg_len = '0;
      endcase
   end

   assign next_coord = (horiz_ff ? cur_x_ff : cur_y_ff) + DW'(1);
   assign edge_hit   = horiz_ff ? (next_coord >= cfg.eff_w) : (next_coord >= cfg.eff_h);

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_ready;
      res_data_in   = res_data_ff;
      res_rej_in    = res_rej_ff;
      seg_in        = seg_ff;
      cur_x_in      = cur_x_ff;
      cur_y_in      = cur_y_ff;
      left_in       = left_ff;
      horiz_in      = horiz_ff;
      fill_addr_in  = fill_addr_ff;
      fill_count_in = fill_count_ff;
      wr_en_in      = 1'b0;
      wr_addr_in    = wr_addr_ff;
      wr_data_in    = wr_data_ff;
      rd_en         = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd_in = req_data;
               if (cfg.color_mode) begin
                  cmd_in.draw_color = {16'h0000, req_data.draw_color[15:0]};
               end
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            res_data_in   = '0;
            res_rej_in    = 1'b0;
            cur_x_in      = cmd_ff.pos_x[DW-1:0];
            cur_y_in      = cmd_ff.pos_y[DW-1:0];
            fill_count_in = product[AW:0];
            fill_addr_in  = '0;
            seg_in        = SEG_TOP;
            if (!cfg.enabled || (cmd_ff.req_type > fdraw_pkg::CMD_READ)) begin
               res_rej_in = 1'b1;
               state_in   = ST_DONE;
            end else if (cmd_ff.req_type == fdraw_pkg::CMD_PIXEL) begin
               state_in = ST_SETUP;
            end else if (cmd_ff.req_type == fdraw_pkg::CMD_FILL) begin
               state_in = ST_FILL;
            end else if (!in_frame(x_ext, y_ext, cfg.eff_w, cfg.eff_h)) begin
               res_rej_in = 1'b1;
               state_in   = ST_DONE;
            end else if (cmd_ff.req_type == fdraw_pkg::CMD_READ) begin
               state_in = ST_READ;
            end else if (cmd_ff.req_type == fdraw_pkg::CMD_HLINE) begin
               res_rej_in = !ea_pos;
               state_in   = ea_pos ? ST_SETUP : ST_DONE;
            end else if (cmd_ff.req_type == fdraw_pkg::CMD_VLINE) begin
               seg_in     = SEG_LEFT;
               res_rej_in = !ea_pos;
               state_in   = ea_pos ? ST_SETUP : ST_DONE;
            end else begin
               res_rej_in = !(ea_pos && eb_pos);
               state_in   = (ea_pos && eb_pos) ? ST_SETUP : ST_DONE;
            end
         end
         ST_SETUP: begin
            if (seg_vis) begin
               cur_x_in = seg_x[DW-1:0];
               cur_y_in = seg_y[DW-1:0];
               left_in  = seg_len;
               horiz_in = (seg_ff == SEG_TOP) || (seg_ff == SEG_BOTTOM);
               state_in = ST_WALK;
            end else if (seg_last) begin
               state_in = ST_DONE;
            end else begin
               seg_in = seg_ff + 2'd1;
            end
         end
         ST_WALK: begin
            wr_en_in   = 1'b1;
            wr_addr_in = pix_addr;
            wr_data_in = cmd_ff.draw_color;
            left_in    = left_ff - LW'(1);
            if (horiz_ff) begin
               cur_x_in = next_coord;
            end else begin
               cur_y_in = next_coord;
            end
            if ((left_ff == LW'(1)) || edge_hit) begin
               if (seg_last) begin
                  state_in = ST_DONE;
               end else begin
                  seg_in   = seg_ff + 2'd1;
                  state_in = ST_SETUP;
               end
            end
         end
         ST_FILL: begin
            wr_en_in     = 1'b1;
            wr_addr_in   = fill_addr_ff;
            wr_data_in   = cmd_ff.draw_color;
            fill_addr_in = fill_addr_ff + AW'(1);
            if (({1'b0, fill_addr_ff} + (AW+1)'(1)) == fill_count_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_READ: begin
            rd_en    = 1'b1;
            state_in = ST_RDATA;
         end
         ST_RDATA: begin
            res_data_in = rd_data_ff;
            state_in    = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in     = 1'b1;
               rsp_in.read_data = res_data_ff;
               rsp_in.rejected  = res_rej_ff;
               state_in         = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         wr_en_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         wr_en_ff     <= wr_en_in;
      end
      cmd_ff        <= cmd_in;
      rsp_ff        <= rsp_in;
      res_data_ff   <= res_data_in;
      res_rej_ff    <= res_rej_in;
      seg_ff        <= seg_in;
      cur_x_ff      <= cur_x_in;
      cur_y_ff      <= cur_y_in;
      left_ff       <= left_in;
      horiz_ff      <= horiz_in;
      fill_addr_ff  <= fill_addr_in;
      fill_count_ff <= fill_count_in;
      wr_addr_ff    <= wr_addr_in;
      wr_data_ff    <= wr_data_in;
   end

   // frame memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (wr_en_ff) begin
         frame_mem[wr_addr_ff] <= wr_data_ff;
      end
      if (rd_en) begin
         rd_data_ff <= frame_mem[pix_addr];
      end
   end

endmodule
